### rtl/core/risc_subset_instruction_execute_assert.svh
// Assertion macros for the instruction execute block
`ifndef RISC_SUBSET_INSTRUCTION_EXECUTE_ASSERT_SVH
`define RISC_SUBSET_INSTRUCTION_EXECUTE_ASSERT_SVH

// Assert that an implication holds at every clock edge outside reset
`define RSIE_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that a condition holds at every clock edge outside reset
`define RSIE_ASSERT_ALWAYS(label, clk_s, rst_s, cond) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) \
    else $error("assertion failed");

`endif

### rtl/core/rsie_pkg.sv
// ----------------------------------------------------------------------------
// rsie_pkg
// Operation codes and the decoded word passed from front to back end.
// ----------------------------------------------------------------------------
package rsie_pkg;

  typedef enum logic [4:0] {
    OP_J = 5'd0, OP_JR = 5'd1, OP_BEQ = 5'd2, OP_BLTZ = 5'd3, OP_BGTZ = 5'd4,
    OP_BREAK = 5'd5, OP_SW = 5'd6, OP_LW = 5'd7, OP_SLL = 5'd8, OP_SRL = 5'd9,
    OP_SRA = 5'd10, OP_NOP = 5'd11, OP_ADD = 5'd12, OP_SUB = 5'd13,
    OP_MUL = 5'd14, OP_AND = 5'd15, OP_OR = 5'd16, OP_XOR = 5'd17,
    OP_NOR = 5'd18, OP_SLT = 5'd19, OP_ADDI = 5'd20, OP_ANDI = 5'd21,
    OP_ORI = 5'd22, OP_XORI = 5'd23
  } op_t;

  // Instruction class picked by the front end
  typedef enum logic [2:0] {
    CL_CTRL, CL_MEM, CL_ALU, CL_NOP, CL_BAD
  } cls_t;

  typedef struct packed {
    logic [4:0]  op;
    cls_t        cls;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [31:0] imm;
    logic [31:0] jt;
  } dec_t;

  localparam int DEC_W = $bits(dec_t);

endpackage

### rtl/core/rsie_queue.sv
// ----------------------------------------------------------------------------
// rsie_queue
// Two-entry word queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rsie_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rsie_pkg::dec_t        in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rsie_pkg::dec_t        out_data
);
  import rsie_pkg::*;

  dec_t       slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_stall  = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`include "risc_subset_instruction_execute_assert.svh"
  `RSIE_ASSERT_ALWAYS(a_q_count, clk, rst, count != 2'd3)
  `RSIE_ASSERT_IMPL(a_q_ptr, clk, rst, count == 2'd0 || count == 2'd2, rd_ptr == wr_ptr)
  `RSIE_ASSERT_IMPL(a_q_ptr1, clk, rst, count == 2'd1, rd_ptr != wr_ptr)

endmodule

### rtl/core/rsie_front.sv
// ----------------------------------------------------------------------------
// rsie_front
// Accepts instruction words and classifies them into a registered stage.
// ----------------------------------------------------------------------------
module rsie_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [4:0]            req_type,
  input  logic [4:0]            src_reg,
  input  logic [4:0]            tgt_reg,
  input  logic [4:0]            dst_reg,
  input  logic [4:0]            shift_amount,
  input  logic signed [31:0]    immediate,
  input  logic [31:0]           jump_target,
  output logic                  dec_valid,
  input  logic                  dec_stall,
  output rsie_pkg::dec_t        dec_data
);
  import rsie_pkg::*;

  dec_t stage;
  logic full;
  cls_t cls;

  // classify the operation
  always_comb begin
    case (req_type) inside
      OP_J, OP_JR, OP_BEQ, OP_BLTZ, OP_BGTZ, OP_BREAK: cls = CL_CTRL;
      OP_SW, OP_LW:                                    cls = CL_MEM;
      OP_NOP:                                          cls = CL_NOP;
      [OP_SLL:OP_SRA], [OP_ADD:OP_XORI]:               cls = CL_ALU;
      default:                                         cls = CL_BAD;
    endcase
  end

  assign in_stall  = full && dec_stall;
  assign dec_valid = full;
  assign dec_data  = stage;

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage <= '{op: req_type, cls: cls, rs: src_reg, rt: tgt_reg, rd: dst_reg,
                 sa: shift_amount, imm: immediate, jt: jump_target};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!in_stall) begin
      full <= in_valid;
    end
  end

endmodule

### rtl/core/rsie_back.sv
// ----------------------------------------------------------------------------
// rsie_back
// Executes one word per cycle unless stalled: register file, data memory,
// pc, counter. Memory is cleared by a sweep after reset; result registered.
// ----------------------------------------------------------------------------
module rsie_back #(
  parameter int MEM_WORDS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_idx,
  input  logic                  cfg_ok,
  input  logic [31:0]           cfg_data,
  input  logic                  q_valid,
  output logic                  q_stall,
  input  rsie_pkg::dec_t        q_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           pc_after,
  output logic                  reg_written,
  output logic [4:0]            written_reg,
  output logic signed [31:0]    written_value,
  output logic                  mem_written,
  output logic [9:0]            mem_word_index,
  output logic                  addr_fault,
  output logic                  halted,
  output logic [31:0]           cycle_number
);
  import rsie_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  logic [31:0] regs [32];
  logic [31:0] mem  [MEM_WORDS];
  logic [31:0] pc;
  logic [31:0] cyc;
  logic [31:0] halt_pc;
  logic        clearing;
  logic [AW:0] clr_cnt;

  // load in flight: the write-back reads the registered memory word
  logic        ld_pend;
  logic [4:0]  ld_reg;
  logic [31:0] mem_q;

  logic        fire;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] nxt;
  logic [31:0] sum;
  logic [29:0] widx;
  logic        flt;
  logic        wr;
  logic [4:0]  wreg;
  logic [31:0] wval;
  logic        mw;
  logic        hlt;
  logic        adv;

  // one in flight result register; a load needs the memory read first
  assign q_stall = clearing || ld_pend || (out_valid && out_stall);
  assign fire    = q_valid && !q_stall;

  // operand read; a pending load holds the queue until its write-back
  always_comb begin
    a = regs[q_data.rs];
    b = regs[q_data.rt];
  end

  always_comb begin
    nxt  = pc + 32'd4;
    sum  = a + q_data.imm;
    widx = sum[31:2];
    flt  = 1'b0;
    wr   = 1'b0;
    wreg = 5'd0;
    wval = 32'd0;
    mw   = 1'b0;
    hlt  = 1'b0;
    adv  = 1'b1;
    case (q_data.op)
      OP_J:     nxt = q_data.jt;
      OP_JR:    nxt = a;
      OP_BEQ:   if (a == b) nxt = pc + 32'd4 + q_data.imm;
      OP_BLTZ:  if (a[31]) nxt = pc + 32'd4 + q_data.imm;
      OP_BGTZ:  if (a != 32'd0 && !a[31]) nxt = pc + 32'd4 + q_data.imm;
      OP_BREAK: begin
        nxt = halt_pc;
        hlt = 1'b1;
        adv = 1'b0;
      end
      OP_SW, OP_LW: begin
        flt = sum[31] || (widx >= 30'(MEM_WORDS));
        mw  = !flt && (q_data.op == OP_SW);
      end
      OP_SLL:  begin wr = 1'b1; wreg = q_data.rd; wval = b << q_data.sa; end
      OP_SRL:  begin wr = 1'b1; wreg = q_data.rd; wval = b >> q_data.sa; end
      OP_SRA:  begin wr = 1'b1; wreg = q_data.rd;
                     wval = 32'($signed(b) >>> q_data.sa); end
      OP_NOP:  ;
      OP_ADD:  begin wr = 1'b1; wreg = q_data.rd; wval = a + b; end
      OP_SUB:  begin wr = 1'b1; wreg = q_data.rd; wval = a - b; end
      OP_MUL:  begin wr = 1'b1; wreg = q_data.rd; wval = a * b; end
      OP_AND:  begin wr = 1'b1; wreg = q_data.rd; wval = a & b; end
      OP_OR:   begin wr = 1'b1; wreg = q_data.rd; wval = a | b; end
      OP_XOR:  begin wr = 1'b1; wreg = q_data.rd; wval = a ^ b; end
      OP_NOR:  begin wr = 1'b1; wreg = q_data.rd; wval = ~(a | b); end
      OP_SLT:  begin wr = 1'b1; wreg = q_data.rd;
                     wval = {31'd0, $signed(a) < $signed(b)}; end
      OP_ADDI: begin wr = 1'b1; wreg = q_data.rt; wval = sum; end
      OP_ANDI: begin wr = 1'b1; wreg = q_data.rt; wval = a & q_data.imm; end
      OP_ORI:  begin wr = 1'b1; wreg = q_data.rt; wval = a | q_data.imm; end
      OP_XORI: begin wr = 1'b1; wreg = q_data.rt; wval = a ^ q_data.imm; end
      default: nxt = pc;
    endcase
  end

  // data memory: clearing sweep, store port, registered read
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt[AW-1:0]] <= 32'd0;
    end else if (fire && mw) begin
      mem[widx[AW-1:0]] <= b;
    end
    mem_q <= mem[widx[AW-1:0]];
  end

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) regs[i] <= 32'd0;
    end else if (ld_pend) begin
      regs[ld_reg] <= mem_q;
    end else if (fire && wr) begin
      regs[wreg] <= wval;
    end
  end

  // control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= 32'd0;
      halt_pc   <= 32'd0;
      cyc       <= 32'd1;
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      ld_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we && cfg_ok && !cfg_idx) pc <= cfg_data;
      if (cfg_we && cfg_ok && cfg_idx) halt_pc <= cfg_data;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == (AW+1)'(MEM_WORDS - 1)) clearing <= 1'b0;
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      ld_pend <= 1'b0;
      if (ld_pend) begin
        written_value <= mem_q;
        out_valid     <= 1'b1;
      end
      if (fire) begin
        pc             <= nxt;
        if (adv) cyc   <= cyc + 32'd1;
        pc_after       <= nxt;
        cycle_number   <= cyc;
        halted         <= hlt;
        addr_fault     <= flt;
        mem_written    <= mw;
        mem_word_index <= (q_data.cls == CL_MEM) && !flt ? widx[9:0] : 10'd0;
        if (q_data.op == OP_LW && !flt) begin
          ld_pend     <= 1'b1;
          ld_reg      <= q_data.rt;
          reg_written <= 1'b1;
          written_reg <= q_data.rt;
        end else begin
          out_valid     <= 1'b1;
          reg_written   <= wr;
          written_reg   <= wreg;
          written_value <= wval;
        end
      end
    end
  end

`include "risc_subset_instruction_execute_assert.svh"
  `RSIE_ASSERT_IMPL(a_no_fire_clear, clk, rst, clearing, !fire)
  `RSIE_ASSERT_IMPL(a_no_fire_load, clk, rst, ld_pend, !fire)
  `RSIE_ASSERT_IMPL(a_fault_no_write, clk, rst, out_valid && addr_fault,
                    !mem_written && !reg_written)

endmodule

### rtl/core/risc_subset_instruction_execute.sv
// ----------------------------------------------------------------------------
// risc_subset_instruction_execute
// Executes decoded integer instructions against a register file and memory.
//
//   channel | direction | handshake
//   in      | input     | in_valid / in_stall
//   out     | output    | out_valid / out_stall
//   cfg     | input     | cfg_we / cfg_index / cfg_data
//
// One word per cycle for non-load operations while the output does not stall;
// a load in range holds the back end for a registered data memory read, then
// write-back. Input passes through the front stage register and the queue
// into the result register; a load in range adds the registered memory read.
// After reset the data memory is cleared by a sweep over all MEM_WORDS words;
// no word is taken from the queue during the sweep.
// Stalls on the output hold the result register; the queue absorbs the front.
// ----------------------------------------------------------------------------
module risc_subset_instruction_execute #(
  parameter int MEM_WORDS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         req_type,
  input  logic [4:0]         src_reg,
  input  logic [4:0]         tgt_reg,
  input  logic [4:0]         dst_reg,
  input  logic [4:0]         shift_amount,
  input  logic signed [31:0] immediate,
  input  logic [31:0]        jump_target,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        pc_after,
  output logic               reg_written,
  output logic [4:0]         written_reg,
  output logic signed [31:0] written_value,
  output logic               mem_written,
  output logic [9:0]         mem_word_index,
  output logic               addr_fault,
  output logic               halted,
  output logic [31:0]        cycle_number
);
  import rsie_pkg::*;

  logic f_valid, f_stall, b_valid, b_stall;
  dec_t f_data, b_data;

  rsie_front u_front (
    .clk, .rst, .in_valid, .in_stall, .req_type, .src_reg, .tgt_reg,
    .dst_reg, .shift_amount, .immediate, .jump_target,
    .dec_valid(f_valid), .dec_stall(f_stall), .dec_data(f_data)
  );

  rsie_queue u_queue (
    .clk, .rst, .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
    .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data)
  );

  rsie_back #(.MEM_WORDS(MEM_WORDS)) u_back (
    .clk, .rst, .cfg_we, .cfg_idx(cfg_index[0]), .cfg_ok(!cfg_index[1]),
    .cfg_data, .q_valid(b_valid), .q_stall(b_stall), .q_data(b_data),
    .out_valid, .out_stall, .pc_after, .reg_written, .written_reg,
    .written_value, .mem_written, .mem_word_index, .addr_fault, .halted,
    .cycle_number
  );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Instruction execute testbench
// Drives decoded instructions through the valid/stall input channel, predicts
// register file, data memory, pc and cycle count updates per word, and checks
// every result field in order. Runs several idling phases and config settings.
// ----------------------------------------------------------------------------
module testbench;
  import rsie_pkg::*;

  localparam int MEM_WORDS = 1024;
  localparam int CFG_START_PC = 0;
  localparam int CFG_HALT_MARKER = 1;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [4:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [31:0] imm;
    logic [31:0] jt;
  } instr_t;

  typedef struct {
    logic [31:0] pc;
    logic        rw;
    logic [4:0]  rreg;
    logic [31:0] rval;
    logic        mw;
    logic [9:0]  widx;
    logic        fault;
    logic        halt;
    logic [31:0] cyc;
  } effect_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [4:0] req_type = '0, src_reg = '0, tgt_reg = '0, dst_reg = '0, shift_amount = '0;
  logic signed [31:0] immediate = '0;
  logic [31:0] jump_target = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [31:0] pc_after, cycle_number;
  logic reg_written, mem_written, addr_fault, halted;
  logic [4:0] written_reg;
  logic signed [31:0] written_value;
  logic [9:0] mem_word_index;

  risc_subset_instruction_execute uut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] gpr [32];
  logic [31:0] dmem [MEM_WORDS];
  logic [31:0] pc_model, cyc_model, start_pc_model, halt_pc_model;

  instr_t  pending_instrs[$];
  effect_t expected_effects[$];
  int send_idle_pct = 0, stall_pct = 0;
  bit failed = 0;
  int unsigned cycles = 0;

  function automatic effect_t execute(instr_t w);
    effect_t e;
    logic [31:0] a, b, nxt, sum;
    a = gpr[w.rs];
    b = gpr[w.rt];
    nxt = pc_model + 32'd4;
    e = '{pc: 0, rw: 0, rreg: 0, rval: 0, mw: 0, widx: 0, fault: 0, halt: 0,
          cyc: cyc_model};
    case (w.op)
      OP_J:     nxt = w.jt;
      OP_JR:    nxt = a;
      OP_BEQ:   if (a == b) nxt += w.imm;
      OP_BLTZ:  if (a[31]) nxt += w.imm;
      OP_BGTZ:  if (a != 0 && !a[31]) nxt += w.imm;
      OP_BREAK: begin nxt = halt_pc_model; e.halt = 1; end
      OP_SW, OP_LW: begin
        sum = a + w.imm;
        if (sum[31] || (sum >> 2) >= MEM_WORDS) begin
          e.fault = 1;
        end else begin
          e.widx = sum[11:2];
          if (w.op == OP_SW) begin
            dmem[sum >> 2] = b;
            e.mw = 1;
          end else begin
            e.rw = 1; e.rreg = w.rt; e.rval = dmem[sum >> 2];
          end
        end
      end
      OP_SLL:  begin e.rw = 1; e.rreg = w.rd; e.rval = b << w.sa; end
      OP_SRL:  begin e.rw = 1; e.rreg = w.rd; e.rval = b >> w.sa; end
      OP_SRA:  begin e.rw = 1; e.rreg = w.rd; e.rval = $signed(b) >>> w.sa; end
      OP_NOP:  ;
      OP_ADD:  begin e.rw = 1; e.rreg = w.rd; e.rval = a + b; end
      OP_SUB:  begin e.rw = 1; e.rreg = w.rd; e.rval = a - b; end
      OP_MUL:  begin e.rw = 1; e.rreg = w.rd; e.rval = a * b; end
      OP_AND:  begin e.rw = 1; e.rreg = w.rd; e.rval = a & b; end
      OP_OR:   begin e.rw = 1; e.rreg = w.rd; e.rval = a | b; end
      OP_XOR:  begin e.rw = 1; e.rreg = w.rd; e.rval = a ^ b; end
      OP_NOR:  begin e.rw = 1; e.rreg = w.rd; e.rval = ~(a | b); end
      OP_SLT:  begin e.rw = 1; e.rreg = w.rd; e.rval = {31'd0, $signed(a) < $signed(b)}; end
      OP_ADDI: begin e.rw = 1; e.rreg = w.rt; e.rval = a + w.imm; end
      OP_ANDI: begin e.rw = 1; e.rreg = w.rt; e.rval = a & w.imm; end
      OP_ORI:  begin e.rw = 1; e.rreg = w.rt; e.rval = a | w.imm; end
      OP_XORI: begin e.rw = 1; e.rreg = w.rt; e.rval = a ^ w.imm; end
      default: nxt = pc_model;
    endcase
    if (e.rw) gpr[e.rreg] = e.rval;
    pc_model = nxt;
    if (!e.halt) cyc_model = cyc_model + 1;
    e.pc = nxt;
    return e;
  endfunction

  // driver: present next word, hold it while stalled
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (pending_instrs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          instr_t w;
          w = pending_instrs.pop_front();
          expected_effects.push_back(execute(w));
          in_valid <= 1;
          req_type <= w.op; src_reg <= w.rs; tgt_reg <= w.rt; dst_reg <= w.rd;
          shift_amount <= w.sa; immediate <= w.imm; jump_target <= w.jt;
        end else begin
          in_valid <= 0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic mismatch(string field, logic [31:0] exp_v, logic [31:0] act_v);
    $display("%0t mismatch %s: expected %h actual %h", $time, field, exp_v, act_v);
    failed = 1;
  endtask

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    cycles++;
    if (!rst && out_valid && !out_stall) begin
      if (expected_effects.size() == 0) begin
        $display("%0t unexpected result word, pc %h", $time, pc_after);
        failed = 1;
      end else begin
        effect_t e;
        e = expected_effects.pop_front();
        if (pc_after !== e.pc) mismatch("pc_after", e.pc, pc_after);
        if (reg_written !== e.rw) mismatch("reg_written", e.rw, reg_written);
        if (written_reg !== e.rreg) mismatch("written_reg", e.rreg, written_reg);
        if (written_value !== e.rval) mismatch("written_value", e.rval, written_value);
        if (mem_written !== e.mw) mismatch("mem_written", e.mw, mem_written);
        if (mem_word_index !== e.widx) mismatch("mem_word_index", e.widx, mem_word_index);
        if (addr_fault !== e.fault) mismatch("addr_fault", e.fault, addr_fault);
        if (halted !== e.halt) mismatch("halted", e.halt, halted);
        if (cycle_number !== e.cyc) mismatch("cycle_number", e.cyc, cycle_number);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic instr_t make_instr(logic [4:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sa, logic [31:0] imm,
                                        logic [31:0] jt);
    instr_t w;
    w = '{op: op, rs: rs, rt: rt, rd: rd, sa: sa, imm: imm, jt: jt};
    return w;
  endfunction

  // random word biased toward small registers and in-range addresses
  function automatic instr_t random_instr();
    instr_t w;
    int kind;
    w.op = (($urandom_range(99) < 3) ? 5'($urandom_range(31, 24))
                                     : 5'($urandom_range(23)));
    w.rs = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
    w.rt = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
    w.rd = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
    w.sa = 5'($urandom);
    w.jt = $urandom;
    kind = $urandom_range(9);
    if (w.op == OP_SW || w.op == OP_LW) begin
      if (kind < 7) w.imm = 32'($urandom_range(4 * MEM_WORDS - 1)) - gpr[w.rs];
      else if (kind < 9) w.imm = 32'($urandom_range(12)) - 32'd6 - gpr[w.rs];
      else w.imm = $urandom;
    end else begin
      w.imm = (kind < 5) ? 32'($urandom_range(64)) - 32'd32 : $urandom;
    end
    return w;
  endfunction

  task automatic write_cfg(int idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= 2'(idx); cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_START_PC) begin
      start_pc_model = val;
      pc_model = val;
    end else begin
      halt_pc_model = val;
    end
  endtask

  task automatic wait_drained();
    while (pending_instrs.size() > 0 || expected_effects.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase_idle[4] = '{0, 77, 0, 14};
    int phase_stall[4] = '{0, 0, 77, 14};
    logic [31:0] pcs[4] = '{32'h0, 32'hFFFF_FFFC, 32'h0000_1000, 32'h8000_0000};
    logic [31:0] halts[4] = '{32'hFFFF_FFFF, 32'h0, 32'hDEAD_BEE0, 32'h7FFF_FFFF};
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    start_pc_model = 0; halt_pc_model = 0; pc_model = 0; cyc_model = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, every op, faults, register zero, unknown op
    pending_instrs.push_back(make_instr(OP_ADDI, 0, 1, 0, 0, 32'h7FFF_FFFF, 0));
    pending_instrs.push_back(make_instr(OP_ADDI, 0, 2, 0, 0, 32'h8000_0000, 0));
    pending_instrs.push_back(make_instr(OP_ADD, 1, 1, 3, 0, 0, 0));
    pending_instrs.push_back(make_instr(OP_SUB, 2, 1, 4, 0, 0, 0));
    pending_instrs.push_back(make_instr(OP_MUL, 1, 2, 5, 0, 0, 0));
    pending_instrs.push_back(make_instr(OP_SLL, 0, 1, 6, 31, 0, 0));
    pending_instrs.push_back(make_instr(OP_SRL, 0, 2, 7, 31, 0, 0));
    pending_instrs.push_back(make_instr(OP_SRA, 0, 2, 8, 31, 0, 0));
    pending_instrs.push_back(make_instr(OP_AND, 1, 2, 9, 0, 0, 0));
    pending_instrs.push_back(make_instr(OP_OR, 1, 2, 10, 0, 0, 0));
    pending_instrs.push_back(make_instr(OP_XOR, 1, 1, 11, 0, 0, 0));
    pending_instrs.push_back(make_instr(OP_NOR, 1, 2, 31, 0, 0, 0));
    pending_instrs.push_back(make_instr(OP_SLT, 2, 1, 12, 0, 0, 0));
    pending_instrs.push_back(make_instr(OP_ANDI, 31, 13, 0, 0, 32'hFFFF_FFFF, 0));
    pending_instrs.push_back(make_instr(OP_ORI, 0, 14, 0, 0, 32'h0000_0FFC, 0));
    pending_instrs.push_back(make_instr(OP_XORI, 1, 0, 0, 0, 32'hFFFF_FFFF, 0));
    pending_instrs.push_back(make_instr(OP_SW, 14, 2, 0, 0, 0, 0));  // last word
    pending_instrs.push_back(make_instr(OP_LW, 14, 15, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(OP_LW, 14, 16, 0, 0, 4, 0));  // beyond memory
    pending_instrs.push_back(make_instr(OP_SW, 20, 1, 0, 0, 32'hFFFF_FFFD, 0));  // negative
    pending_instrs.push_back(make_instr(OP_BEQ, 1, 1, 0, 0, 32'hFFFF_FFF0, 0));
    pending_instrs.push_back(make_instr(OP_BLTZ, 2, 0, 0, 0, 32'h40, 0));
    pending_instrs.push_back(make_instr(OP_BGTZ, 1, 0, 0, 0, 32'h8000_0000, 0));
    pending_instrs.push_back(make_instr(OP_J, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    pending_instrs.push_back(make_instr(OP_JR, 2, 0, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(OP_BREAK, 0, 0, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(OP_NOP, 0, 0, 0, 0, 0, 0));
    pending_instrs.push_back(make_instr(5'd31, 31, 31, 31, 31, 32'hFFFF_FFFF, 0));
    wait_drained();

    // random phases, each with its own config setting
    for (int p = 0; p < 4; p++) begin
      write_cfg(CFG_START_PC, pcs[p]);
      write_cfg(CFG_HALT_MARKER, halts[p]);
      send_idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int i = 0; i < 381; i++) begin
        // generate against the live model only once the queue is empty,
        // so address offsets track current base registers
        while (pending_instrs.size() > 0) @(posedge clk);
        pending_instrs.push_back(random_instr());
      end
      wait_drained();
    end

    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
